@@ hw/rtl/hpq_pkg.sv @@
package hpq_pkg;

  localparam int DEPTH_DEF       = 256;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int HANDLE_BITS_DEF = 9;

  localparam int CAP_BITS        = 9;
  localparam int COUNT_OUT_BITS  = 9;
  localparam int STATUS_BITS     = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

endpackage

@@ hw/rtl/hpq_ram.sv @@
module hpq_ram #(
  parameter int Depth    = 256,
  parameter int AddrBits = 8,
  parameter int Width    = 25
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [Width-1:0]    wdata,
  input  logic [AddrBits-1:0] raddr_a,
  input  logic [AddrBits-1:0] raddr_b,
  output logic [Width-1:0]    rdata_a,
  output logic [Width-1:0]    rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/min_heap_priority_queue_core.sv @@
// Channel   Handshake                 Payload
// command   start / busy              mode, entry_weight, entry_handle
// result    done (one-cycle strobe)   status, out_weight, out_handle, entry_count
// config    cfg_valid / cfg_ready     cfg_data (capacity)
//
// Insert: S_UP moves the new entry up one heap level at a time past heavier parents.
// Remove: S_DN_LOAD takes in the root and last entry, then S_DN_CMP moves the last
// entry down a level at a time while two or more entries remain. Each level costs
// one write and one read (two when descending) of the dual-read-port heap memory.
// Refused inserts and removes from an empty heap are answered directly from S_IDLE.
// Reset empties the heap at once (count cleared); capacity returns to 256.
// The result strobe cannot be stalled; busy drops in the cycle done is high.
module min_heap_priority_queue_core #(
  parameter int DEPTH       = hpq_pkg::DEPTH_DEF,
  parameter int WEIGHT_BITS = hpq_pkg::WEIGHT_BITS_DEF,
  parameter int HANDLE_BITS = hpq_pkg::HANDLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [WEIGHT_BITS-1:0]              entry_weight,
  input  logic [HANDLE_BITS-1:0]              entry_handle,
  output logic                                done,
  output logic [hpq_pkg::STATUS_BITS-1:0]     status,
  output logic [WEIGHT_BITS-1:0]              out_weight,
  output logic [HANDLE_BITS-1:0]              out_handle,
  output logic [hpq_pkg::COUNT_OUT_BITS-1:0]  entry_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hpq_pkg::CAP_BITS-1:0]        cfg_data
);

  import hpq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int WW = WEIGHT_BITS + HANDLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LOAD,
    S_DN_CMP,
    S_WR
  } state_t;

  state_t               state;
  logic [CW-1:0]        count;
  logic [CAP_BITS-1:0]  capacity;
  logic [CW-1:0]        pos;
  logic [WW-1:0]        x_word;
  logic [WW-1:0]        top_word;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WW-1:0]        wdata;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic [WW-1:0]        rdata_a;
  logic [WW-1:0]        rdata_b;

  logic [LW-1:0]        cap_ext;
  logic [LW-1:0]        depth_ext;
  logic [LW-1:0]        limit;
  logic                 full;
  logic [CW-1:0]        ins_pos;
  logic                 up_go;
  logic [CW:0]          child;
  logic [CW:0]          child_r;
  logic [CW:0]          count_ext;
  logic                 take_r;
  logic [WW-1:0]        sel_word;
  logic [CW:0]          sel_pos;
  logic                 dn_stop;
  logic [CW:0]          nchild;
  logic                 dn_more;
  logic [WEIGHT_BITS-1:0] x_w;

  hpq_ram #(
    .Depth    (DEPTH),
    .AddrBits (AW),
    .Width    (WW)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign cap_ext   = LW'(capacity);
  assign depth_ext = LW'(DEPTH);
  assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = LW'(count) >= limit;
  assign ins_pos   = count + 1'b1;

  assign x_w       = x_word[WW-1:HANDLE_BITS];
  assign up_go     = (pos > CW'(1)) && (x_w < rdata_a[WW-1:HANDLE_BITS]);

  assign count_ext = {1'b0, count};
  assign child     = {pos, 1'b0};
  assign child_r   = child + 1'b1;
  assign take_r    = (child != count_ext) &&
                     (rdata_a[WW-1:HANDLE_BITS] > rdata_b[WW-1:HANDLE_BITS]);
  assign sel_word  = take_r ? rdata_b : rdata_a;
  assign sel_pos   = take_r ? child_r : child;
  assign dn_stop   = x_w <= sel_word[WW-1:HANDLE_BITS];
  assign nchild    = {sel_pos[CW-1:0], 1'b0};
  assign dn_more   = nchild <= count_ext;

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_a = '0;
    raddr_b = '0;
    case (state)
      S_IDLE: begin
        if (mode == MODE_INSERT) begin
          raddr_a = AW'((ins_pos >> 1) - 1'b1);
        end else begin
          raddr_a = '0;
          raddr_b = AW'(count - 1'b1);
        end
      end
      S_UP: begin
        we    = 1'b1;
        waddr = AW'(pos - 1'b1);
        if (up_go) begin
          wdata   = rdata_a;
          raddr_a = AW'((pos >> 2) - 1'b1);
        end else begin
          wdata = x_word;
        end
      end
      S_DN_LOAD: begin
        if (count > CW'(1)) begin
          raddr_a = AW'(1);
          raddr_b = AW'(2);
        end else begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata_b;
        end
      end
      S_DN_CMP: begin
        we    = 1'b1;
        waddr = AW'(pos - 1'b1);
        if (dn_stop) begin
          wdata = x_word;
        end else begin
          wdata   = sel_word;
          raddr_a = AW'(nchild - 1'b1);
          raddr_b = AW'(nchild);
        end
      end
      S_WR: begin
        we    = 1'b1;
        waddr = AW'(pos - 1'b1);
        wdata = x_word;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      capacity    <= CAP_RESET;
      done        <= 1'b0;
      status      <= ST_DONE;
      out_weight  <= '0;
      out_handle  <= '0;
      entry_count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            out_weight <= '0;
            out_handle <= '0;
            if (mode == MODE_INSERT) begin
              if (full) begin
                done        <= 1'b1;
                status      <= ST_FULL;
                entry_count <= COUNT_OUT_BITS'(count);
              end else begin
                count  <= ins_pos;
                pos    <= ins_pos;
                x_word <= {entry_weight, entry_handle};
                state  <= S_UP;
              end
            end else begin
              if (count == '0) begin
                done        <= 1'b1;
                status      <= ST_EMPTY;
                entry_count <= COUNT_OUT_BITS'(count);
              end else begin
                count <= count - 1'b1;
                pos   <= CW'(1);
                state <= S_DN_LOAD;
              end
            end
          end
        end
        S_UP: begin
          if (up_go) begin
            pos <= pos >> 1;
          end else begin
            done        <= 1'b1;
            status      <= ST_DONE;
            out_weight  <= '0;
            out_handle  <= '0;
            entry_count <= COUNT_OUT_BITS'(count);
            state       <= S_IDLE;
          end
        end
        S_DN_LOAD: begin
          top_word <= rdata_a;
          x_word   <= rdata_b;
          if (count > CW'(1)) begin
            state <= S_DN_CMP;
          end else begin
            done        <= 1'b1;
            status      <= ST_DONE;
            out_weight  <= rdata_a[WW-1:HANDLE_BITS];
            out_handle  <= rdata_a[HANDLE_BITS-1:0];
            entry_count <= COUNT_OUT_BITS'(count);
            state       <= S_IDLE;
          end
        end
        S_DN_CMP: begin
          if (dn_stop) begin
            done        <= 1'b1;
            status      <= ST_DONE;
            out_weight  <= top_word[WW-1:HANDLE_BITS];
            out_handle  <= top_word[HANDLE_BITS-1:0];
            entry_count <= COUNT_OUT_BITS'(count);
            state       <= S_IDLE;
          end else begin
            pos <= sel_pos[CW-1:0];
            if (!dn_more) begin
              state <= S_WR;
            end
          end
        end
        S_WR: begin
          done        <= 1'b1;
          status      <= ST_DONE;
          out_weight  <= top_word[WW-1:HANDLE_BITS];
          out_handle  <= top_word[HANDLE_BITS-1:0];
          entry_count <= COUNT_OUT_BITS'(count);
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpq_pkg::*;

  localparam int WB          = WEIGHT_BITS_DEF;
  localparam int HB          = HANDLE_BITS_DEF;
  localparam int SLOTS       = DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 19;

  typedef enum {JOB_CMD, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t             kind;
    bit                    calm;
    mode_t                 op;
    logic [WB-1:0]         weight;
    logic [HB-1:0]         handle;
    logic [CAP_BITS-1:0]   cap;
  } job_t;

  typedef struct packed {
    logic [WB-1:0] w;
    logic [HB-1:0] h;
  } heap_ent_t;

  typedef struct {
    status_t                   status;
    logic [WB-1:0]             weight;
    logic [HB-1:0]             handle;
    logic [COUNT_OUT_BITS-1:0] count;
  } heap_result_t;

  bit clk;
  logic rst = 1'b1;
  logic start, mode, cfg_valid;
  logic [WB-1:0] entry_weight;
  logic [HB-1:0] entry_handle;
  logic [CAP_BITS-1:0] cfg_data;
  logic busy, done, cfg_ready;
  logic [STATUS_BITS-1:0] status;
  logic [WB-1:0] out_weight;
  logic [HB-1:0] out_handle;
  logic [COUNT_OUT_BITS-1:0] entry_count;

  job_t         job_queue[$];
  heap_result_t pending_results[$];
  heap_result_t want;
  job_t         nxt;
  bit           cmd_beat, cfg_beat, calm_fill;
  bit           start_n, cfg_n;
  int           fail_count;
  int           stall_cycles;

  heap_ent_t           model_heap [1:SLOTS];
  int unsigned         model_count = 0;
  logic [CAP_BITS-1:0] model_cap = CAP_RESET;

  min_heap_priority_queue_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .entry_weight(entry_weight),
    .entry_handle(entry_handle),
    .done(done),
    .status(status),
    .out_weight(out_weight),
    .out_handle(out_handle),
    .entry_count(entry_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic heap_result_t heap_apply(mode_t op, logic [WB-1:0] w, logic [HB-1:0] h);
    heap_result_t r;
    heap_ent_t x, top;
    int unsigned lim, i, parent, child;
    lim = (model_cap > SLOTS) ? SLOTS : model_cap;
    r.status = ST_DONE;
    r.weight = '0;
    r.handle = '0;
    if (op == MODE_INSERT) begin
      if (model_count >= lim) begin
        r.status = ST_FULL;
      end else begin
        x.w = w;
        x.h = h;
        model_count++;
        i = model_count;
        while (i > 1 && x.w < model_heap[i / 2].w) begin
          model_heap[i] = model_heap[i / 2];
          i = i / 2;
        end
        model_heap[i] = x;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      top = model_heap[1];
      x = model_heap[model_count];
      model_count--;
      parent = 1;
      while (parent * 2 <= model_count) begin
        child = parent * 2;
        if (child != model_count && model_heap[child].w > model_heap[child + 1].w) child++;
        if (x.w <= model_heap[child].w) break;
        model_heap[parent] = model_heap[child];
        parent = child;
      end
      model_heap[parent] = x;
      r.weight = top.w;
      r.handle = top.h;
    end
    r.count = COUNT_OUT_BITS'(model_count);
    return r;
  endfunction

  task automatic add_cmd(mode_t op, logic [WB-1:0] w, logic [HB-1:0] h);
    job_t j;
    j.kind = JOB_CMD;
    j.calm = calm_fill;
    j.op = op;
    j.weight = w;
    j.handle = h;
    j.cap = '0;
    job_queue.push_back(j);
  endtask

  task automatic add_cfg(logic [CAP_BITS-1:0] cap);
    job_t j;
    j.kind = JOB_CFG;
    j.calm = 1'b0;
    j.op = MODE_INSERT;
    j.weight = '0;
    j.handle = '0;
    j.cap = cap;
    job_queue.push_back(j);
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.calm = 1'b0;
    j.op = MODE_INSERT;
    j.weight = '0;
    j.handle = '0;
    j.cap = '0;
    job_queue.push_back(j);
  endtask

  // driver
  always @(negedge clk) begin
    if (cmd_beat || cfg_beat) void'(job_queue.pop_front());
    if (rst || job_queue.size() == 0) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else if ((start && !cmd_beat) || (cfg_valid && !cfg_beat)) begin
      // hold until the beat is taken
    end else begin
      nxt = job_queue[0];
      start_n = 1'b0;
      cfg_n = 1'b0;
      case (nxt.kind)
        JOB_DRAIN: begin
          if (pending_results.size() == 0) void'(job_queue.pop_front());
        end
        JOB_CFG: begin
          if (pending_results.size() == 0 && !busy) begin
            cfg_n = 1'b1;
            cfg_data <= nxt.cap;
          end
        end
        default: begin
          if (nxt.calm || $urandom_range(99) >= IDLE_PCT) begin
            start_n = 1'b1;
            mode <= nxt.op;
            entry_weight <= nxt.weight;
            entry_handle <= nxt.handle;
          end
        end
      endcase
      start <= start_n;
      cfg_valid <= cfg_n;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    cmd_beat <= !rst && start && !busy;
    cfg_beat <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expected result");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
          if (out_weight !== want.weight) begin
            $error("out_weight: expected %0d, got %0d", want.weight, out_weight);
            fail_count++;
          end
          if (out_handle !== want.handle) begin
            $error("out_handle: expected %0d, got %0d", want.handle, out_handle);
            fail_count++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(heap_apply(mode_t'(mode), entry_weight, entry_handle));
      if (cfg_valid && cfg_ready) model_cap = cfg_data;
      if ((start && !busy) || (cfg_valid && cfg_ready) || done === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int sent, len, ins_pct;
    bit narrow;
    logic [CAP_BITS-1:0] cap;
    start = 1'b0;
    mode = 1'b0;
    entry_weight = '0;
    entry_handle = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;

    // directed: empty remove, extremes, ties, capacity corners
    add_cmd(MODE_REMOVE, 16'hFFFF, 9'h1FF);
    add_cmd(MODE_INSERT, 16'h0000, 9'h000);
    add_cmd(MODE_INSERT, 16'hFFFF, 9'h1FF);
    add_cmd(MODE_INSERT, 16'd100, 9'd1);
    add_cmd(MODE_INSERT, 16'd100, 9'd2);
    add_cmd(MODE_INSERT, 16'hAAAA, 9'h155);
    add_cmd(MODE_INSERT, 16'h5555, 9'h0AA);
    add_cmd(MODE_INSERT, 16'h0000, 9'd3);
    repeat (8) add_cmd(MODE_REMOVE, 16'h0000, 9'h000);
    add_cfg(9'd1);
    add_cmd(MODE_INSERT, 16'd7, 9'd7);
    add_cmd(MODE_INSERT, 16'd8, 9'd8);
    add_cmd(MODE_REMOVE, 16'h0000, 9'h000);
    add_cmd(MODE_REMOVE, 16'h0000, 9'h000);
    add_cfg(9'd0);
    add_cmd(MODE_INSERT, 16'd9, 9'd9);
    add_cfg(9'd511);
    repeat (3) add_cmd(MODE_INSERT, 16'($urandom), 9'($urandom));
    add_cfg(9'd2);
    add_cmd(MODE_INSERT, 16'd1, 9'd1);
    add_cmd(MODE_REMOVE, 16'h0000, 9'h000);
    add_cmd(MODE_REMOVE, 16'h0000, 9'h000);
    add_cmd(MODE_INSERT, 16'd2, 9'd2);

    // fill the whole store and empty it again, with no idling
    calm_fill = 1'b1;
    add_cfg(CAP_RESET);
    repeat (260) add_cmd(MODE_INSERT, 16'($urandom), 9'($urandom));
    repeat (260) add_cmd(MODE_REMOVE, 16'($urandom), 9'($urandom));
    calm_fill = 1'b0;

    sent = 0;
    while (sent < 700) begin
      case ($urandom_range(5))
        0: cap = 9'd0;
        1: cap = 9'd1;
        2: cap = CAP_RESET;
        3: cap = 9'd511;
        4: cap = 9'($urandom_range(2, 40));
        default: cap = 9'($urandom_range(511));
      endcase
      add_cfg(cap);
      ins_pct = $urandom_range(30, 75);
      narrow = 1'($urandom_range(1));
      len = $urandom_range(30, 80);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && $urandom_range(3) == 0) add_drain();
        if ($urandom_range(99) < ins_pct)
          add_cmd(MODE_INSERT, narrow ? 16'($urandom_range(7)) : 16'($urandom), 9'($urandom));
        else
          add_cmd(MODE_REMOVE, 16'($urandom), 9'($urandom));
      end
      sent += len;
    end
    add_cfg(CAP_RESET);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (job_queue.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
